### rtl/psp_pkg.sv
// ---------------------------------------------------------------------------
// psp_pkg
// Shared types and constants for the point/segment projection block.
// ---------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

    // projection parameter t is signed Q2.30
    localparam int T_FRAC  = 30;
    localparam int T_WIDTH = T_FRAC + 2;

    typedef enum logic [1:0] {
        CFG_START_X = 2'd0,
        CFG_START_Y = 2'd1,
        CFG_END_X   = 2'd2,
        CFG_END_Y   = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

### rtl/psp_div.sv
// ---------------------------------------------------------------------------
// psp_div
// Pipelined restoring divider, one quotient bit per stage. The first stage
// compares without a shift, every later stage shifts the remainder first.
// ---------------------------------------------------------------------------
`default_nettype none

module psp_div #(
    parameter int NW = 66,
    parameter int QB = 31,
    parameter int SW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [NW-1:0] den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QB-1:0]      quo,
    output logic [SW-1:0]      out_side
);

    logic          v_reg    [QB];
    logic [NW:0]   rem_reg  [QB];
    logic [NW-1:0] den_reg  [QB];
    logic [QB-1:0] q_reg    [QB];
    logic [SW-1:0] side_reg [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic          v_in;
        logic [NW:0]   rem_in;
        logic [NW-1:0] den_in;
        logic [QB-1:0] q_in;
        logic [SW-1:0] side_in;
        logic [NW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = {1'b0, num};
            assign den_in  = den;
            assign q_in    = '0;
            assign side_in = in_side;
            assign trial   = rem_in;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign side_in = side_reg[k-1];
            assign trial   = {rem_in[NW-1:0], 1'b0};
        end

        assign ge = (trial >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (trial - {1'b0, den_in}) : trial;
                den_reg[k]  <= den_in;
                q_reg[k]    <= {q_in[QB-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[QB-1];
    assign quo       = q_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

`default_nettype wire

### rtl/psp_sqrt.sv
// ---------------------------------------------------------------------------
// psp_sqrt
// Pipelined integer square root (floor), one root bit per stage, taking two
// radicand bits from the top in each stage.
// ---------------------------------------------------------------------------
`default_nettype none

module psp_sqrt #(
    parameter int RB = 34,
    parameter int SW = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [2*RB-1:0] radicand,
    input  wire logic [SW-1:0]   in_side,
    output logic                 out_valid,
    output logic [RB-1:0]        root,
    output logic [SW-1:0]        out_side
);

    logic            v_reg    [RB];
    logic [RB+1:0]   rem_reg  [RB];
    logic [RB-1:0]   root_reg [RB];
    logic [2*RB-1:0] rad_reg  [RB];
    logic [SW-1:0]   side_reg [RB];

    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic            v_in;
        logic [RB+1:0]   rem_in;
        logic [RB-1:0]   root_in;
        logic [2*RB-1:0] rad_in;
        logic [SW-1:0]   side_in;
        logic [RB+1:0]   rem_sh;
        logic [RB+1:0]   test;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next two radicand bits
        assign rem_sh = {rem_in[RB-1:0], rad_in[2*RB-1 -: 2]};
        assign test   = {root_in, 2'b01};
        assign ge     = (rem_sh >= test);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_sh - test) : rem_sh;
                root_reg[k] <= {root_in[RB-2:0], ge};
                rad_reg[k]  <= {rad_in[2*RB-3:0], 2'b00};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[RB-1];
    assign root      = root_reg[RB-1];
    assign out_side  = side_reg[RB-1];

endmodule

`default_nettype wire

### rtl/point_segment_projection_top.sv
// ---------------------------------------------------------------------------
// point_segment_projection_top
// Nearest point on a configured line or segment to a query point, with the
// distance to it. Fully pipelined: products, divider, rounding, square root.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle; the 31-stage divider and the
// (COORD_WIDTH+2)-stage root each take a new operand every cycle.
// A stalled output word freezes the whole pipeline until it is taken.
// Reset: asynchronous, clears endpoint registers to 0 and all valid bits.
`default_nettype none

module point_segment_projection_top #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // query_x, query_y
    input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // clamp_to_segment
    input  wire logic [0:0]                             s_axis_tuser,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // nearest_x, nearest_y, gap_distance
    output logic [((3*COORD_WIDTH+1+7)/8)*8-1:0]        m_axis_tdata,
    // zero_length, clipped
    output logic [1:0]                                  m_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire psp_pkg::cfg_reg_t                      cfg_index,
    input  wire logic [COORD_WIDTH-1:0]                 cfg_data
);

    import psp_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int DW      = W + 1;
    localparam int NW      = 2 * DW;
    localparam int PW      = NW + 1;
    localparam int TW      = T_WIDTH;
    localparam int QB      = T_FRAC + 1;
    localparam int RB      = DW + 1;
    localparam int PRW     = DW + TW;
    localparam int SHW     = PRW + 1 - T_FRAC;
    localparam int XW      = SHW + 1;
    localparam int DSW     = 2 * W + 5;
    localparam int QSW     = 2 * W + 2;
    localparam int OUT_TDW = ((3 * W + 1 + 7) / 8) * 8;

    localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [TW-1:0] T_ONE = TW'(1) << T_FRAC;
    localparam logic [PRW:0]         BIAS  = (PRW+1)'(1) << (T_FRAC - 1);

    logic en;

    // endpoint registers
    logic [W-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_X: start_x_reg <= cfg_data;
                CFG_START_Y: start_y_reg <= cfg_data;
                CFG_END_X:   end_x_reg   <= cfg_data;
                CFG_END_Y:   end_y_reg   <= cfg_data;
                default:     start_x_reg <= start_x_reg;
            endcase
        end
    end

    // endpoints must be kept quiet while words are in flight; the block does not enforce this
    logic signed [DW-1:0] sx, sy, dx, dy;
    assign sx = $signed({start_x_reg[W-1], start_x_reg});
    assign sy = $signed({start_y_reg[W-1], start_y_reg});
    assign dx = $signed({end_x_reg[W-1], end_x_reg}) - sx;
    assign dy = $signed({end_y_reg[W-1], end_y_reg}) - sy;

    logic out_valid_reg;
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: offsets from the start point
    logic                 v1_reg, seg1_reg;
    logic [W-1:0]         px1_reg, py1_reg;
    logic signed [DW-1:0] qx1_reg, qy1_reg;
    logic [W-1:0]         in_px, in_py;
    assign in_px = s_axis_tdata[W-1:0];
    assign in_py = s_axis_tdata[2*W-1:W];

    // stage 2: products
    logic                 v2_reg, seg2_reg;
    logic [W-1:0]         px2_reg, py2_reg;
    logic signed [NW-1:0] dxx2_reg, dyy2_reg, qdx2_reg, qdy2_reg;

    // stage 3: length, dot, range flags
    logic                 v3_reg;
    logic [W-1:0]         px3_reg, py3_reg;
    logic                 seg3_reg, zero3_reg, neg3_reg, big3_reg, eq3_reg;
    logic [NW-1:0]        mag3_reg, len3_reg;
    logic signed [PW-1:0] len_c, dot_c, mag_w;
    logic [NW-1:0]        len_u, mag_u;
    logic [PW-1:0]        twice;

    assign len_c = $signed({dxx2_reg[NW-1], dxx2_reg}) + $signed({dyy2_reg[NW-1], dyy2_reg});
    assign dot_c = $signed({qdx2_reg[NW-1], qdx2_reg}) + $signed({qdy2_reg[NW-1], qdy2_reg});
    assign mag_w = dot_c[PW-1] ? -dot_c : dot_c;
    assign len_u = len_c[NW-1:0];
    assign mag_u = mag_w[NW-1:0];
    assign twice = {len_u, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg   <= in_px;
            py1_reg   <= in_py;
            seg1_reg  <= s_axis_tuser[0];
            qx1_reg   <= $signed({in_px[W-1], in_px}) - sx;
            qy1_reg   <= $signed({in_py[W-1], in_py}) - sy;

            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
            seg2_reg  <= seg1_reg;
            dxx2_reg  <= dx * dx;
            dyy2_reg  <= dy * dy;
            qdx2_reg  <= qx1_reg * dx;
            qdy2_reg  <= qy1_reg * dy;

            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            seg3_reg  <= seg2_reg;
            zero3_reg <= (len_u == '0);
            neg3_reg  <= dot_c[PW-1];
            big3_reg  <= ({1'b0, mag_u} >= twice);
            eq3_reg   <= ({1'b0, mag_u} == twice);
            mag3_reg  <= mag_u;
            len3_reg  <= len_u;
        end
    end

    // divider
    logic           vd;
    logic [QB-1:0]  quo;
    logic [DSW-1:0] dside;

    psp_div #(.NW(NW), .QB(QB), .SW(DSW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v3_reg),
        .num      (mag3_reg),
        .den      (len3_reg),
        .in_side  ({px3_reg, py3_reg, seg3_reg, zero3_reg, neg3_reg, big3_reg, eq3_reg}),
        .out_valid(vd),
        .quo      (quo),
        .out_side (dside)
    );

    logic [W-1:0] d_px, d_py;
    logic         d_seg, d_zero, d_neg, d_big, d_eq;
    assign {d_px, d_py, d_seg, d_zero, d_neg, d_big, d_eq} = dside;

    // stage 4: select and clamp t
    logic signed [TW-1:0] t_raw, t_c;
    logic                 tclip;

    always_comb
    begin
        tclip = 1'b0;
        if (d_big)
        begin
            t_raw = d_neg ? T_MIN : T_MAX;
            tclip = d_neg ? !d_eq : 1'b1;
        end
        else
        begin
            t_raw = d_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        end
        priority if (d_zero)
        begin
            t_c = '0;
        end
        else if (d_seg && t_raw < 0)
        begin
            t_c = '0;
        end
        else if (d_seg && t_raw > T_ONE)
        begin
            t_c = T_ONE;
        end
        else
        begin
            t_c = t_raw;
        end
    end

    logic                 v4_reg, zero4_reg, clip4_reg;
    logic [W-1:0]         px4_reg, py4_reg;
    logic signed [TW-1:0] t4_reg;

    // stage 5: scale direction by t
    logic                  v5_reg, zero5_reg, clip5_reg;
    logic [W-1:0]          px5_reg, py5_reg;
    logic signed [PRW-1:0] prx5_reg, pry5_reg;

    // stage 6: round, add start, saturate
    function automatic logic [W:0] round_sat(input logic signed [PRW-1:0] prod,
                                             input logic signed [DW-1:0]  base);
        logic [PRW:0]         b;
        logic signed [XW-1:0] s;
        logic                 ovf;
        b   = {prod[PRW-1], prod} + BIAS;
        s   = $signed({b[PRW], b[PRW:T_FRAC]}) + $signed({{(XW-DW){base[DW-1]}}, base});
        ovf = (s[XW-1:W-1] != {(XW-W+1){1'b0}}) && (s[XW-1:W-1] != {(XW-W+1){1'b1}});
        if (!ovf)
        begin
            round_sat = {1'b0, s[W-1:0]};
        end
        else
        begin
            round_sat = {1'b1, s[XW-1], {(W-1){!s[XW-1]}}};
        end
    endfunction

    logic [W:0]   rx, ry;
    assign rx = round_sat(prx5_reg, sx);
    assign ry = round_sat(pry5_reg, sy);

    logic         v6_reg, zero6_reg, clip6_reg;
    logic [W-1:0] px6_reg, py6_reg, nx6_reg, ny6_reg;

    // stage 7: gap vector
    logic                 v7_reg, zero7_reg, clip7_reg;
    logic [W-1:0]         nx7_reg, ny7_reg;
    logic signed [DW-1:0] gx7_reg, gy7_reg;

    // stage 8: squares
    logic                 v8_reg, zero8_reg, clip8_reg;
    logic [W-1:0]         nx8_reg, ny8_reg;
    logic signed [NW-1:0] sqx8_reg, sqy8_reg;

    // stage 9: radicand
    logic                 v9_reg, zero9_reg, clip9_reg;
    logic [W-1:0]         nx9_reg, ny9_reg;
    logic [2*RB-1:0]      rad9_reg;
    logic [NW-1:0]        rad_sum;
    assign rad_sum = sqx8_reg + sqy8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= vd;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px4_reg   <= d_px;
            py4_reg   <= d_py;
            zero4_reg <= d_zero;
            clip4_reg <= !d_zero && !d_seg && tclip;
            t4_reg    <= t_c;

            px5_reg   <= px4_reg;
            py5_reg   <= py4_reg;
            zero5_reg <= zero4_reg;
            clip5_reg <= clip4_reg;
            prx5_reg  <= dx * t4_reg;
            pry5_reg  <= dy * t4_reg;

            px6_reg   <= px5_reg;
            py6_reg   <= py5_reg;
            zero6_reg <= zero5_reg;
            clip6_reg <= clip5_reg || rx[W] || ry[W];
            nx6_reg   <= rx[W-1:0];
            ny6_reg   <= ry[W-1:0];

            nx7_reg   <= nx6_reg;
            ny7_reg   <= ny6_reg;
            zero7_reg <= zero6_reg;
            clip7_reg <= clip6_reg;
            gx7_reg   <= $signed({px6_reg[W-1], px6_reg}) - $signed({nx6_reg[W-1], nx6_reg});
            gy7_reg   <= $signed({py6_reg[W-1], py6_reg}) - $signed({ny6_reg[W-1], ny6_reg});

            nx8_reg   <= nx7_reg;
            ny8_reg   <= ny7_reg;
            zero8_reg <= zero7_reg;
            clip8_reg <= clip7_reg;
            sqx8_reg  <= gx7_reg * gx7_reg;
            sqy8_reg  <= gy7_reg * gy7_reg;

            nx9_reg   <= nx8_reg;
            ny9_reg   <= ny8_reg;
            zero9_reg <= zero8_reg;
            clip9_reg <= clip8_reg;
            rad9_reg  <= {{(2*RB-NW){1'b0}}, rad_sum};
        end
    end

    // square root
    logic           vs;
    logic [RB-1:0]  root;
    logic [QSW-1:0] sside;

    psp_sqrt #(.RB(RB), .SW(QSW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v9_reg),
        .radicand (rad9_reg),
        .in_side  ({nx9_reg, ny9_reg, zero9_reg, clip9_reg}),
        .out_valid(vs),
        .root     (root),
        .out_side (sside)
    );

    logic [W-1:0] s_nx, s_ny;
    logic         s_zero, s_clip;
    assign {s_nx, s_ny, s_zero, s_clip} = sside;

    // output register
    logic [W-1:0] nx_out_reg, ny_out_reg;
    logic [W:0]   gap_out_reg;
    logic         zero_out_reg, clip_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_out_reg   <= s_nx;
            ny_out_reg   <= s_ny;
            gap_out_reg  <= root[RB-1] ? {(W+1){1'b1}} : root[W:0];
            zero_out_reg <= s_zero;
            clip_out_reg <= s_clip || root[RB-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDW'({gap_out_reg, ny_out_reg, nx_out_reg});
    assign m_axis_tuser  = {clip_out_reg, zero_out_reg};

    // the pipeline only holds back input while a finished word waits
    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no output word waiting");

    // a zero-length line gives the start point exactly: only the gap can clip
    a_zero_no_coord_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (!m_axis_tuser[1] || gap_out_reg == {(W+1){1'b1}}))
        else $error("zero-length word clipped without gap saturation");

    // a word that stalled stays valid on the next cycle
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(gap_out_reg)))
        else $error("stalled output word changed");

endmodule

`default_nettype wire
